### rtl/sart_pkg.sv
// ----------------------------------------------------------------------------
// sart_pkg
// shared types and constants of the sorted address reply table
// ----------------------------------------------------------------------------
`default_nettype none

package sart_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH = 64;

    // fixed field widths
    localparam int ADDR_W  = 32;
    localparam int ID_W    = 16;
    localparam int BYTE_W  = 8;
    localparam int CNT_OUT = 7;

    // command carried in tuser
    typedef enum logic [2:0] {
        K_ADD       = 3'd0,
        K_DELETE    = 3'd1,
        K_QUERY     = 3'd2,
        K_CLEAR     = 3'd3,
        K_REPLY     = 3'd4,
        K_SEND_FAIL = 3'd5,
        K_REPORT    = 3'd6
    } t_kind;

    // result status code
    typedef enum logic [1:0] {
        S_DONE    = 2'd0,
        S_ABSENT  = 2'd1,
        S_FULL    = 2'd2,
        S_PRESENT = 2'd3
    } t_status;

    // reply status kept per entry
    typedef enum logic [1:0] {
        R_NONE      = 2'd0,
        R_OK        = 2'd1,
        R_SEND_FAIL = 2'd2,
        R_ERROR     = 2'd3
    } t_reply;

    // write enables toward the table memories
    typedef struct packed {
        logic addr_we;
        logic stat_we;
    } t_mem_we;

    // one result word before packing
    typedef struct packed {
        t_status              status;
        logic                 answered;
        logic [CNT_OUT-1:0]   entry_count;
        logic [CNT_OUT-1:0]   count_ok;
        logic [CNT_OUT-1:0]   count_error;
        logic [CNT_OUT-1:0]   count_send_fail;
        logic [CNT_OUT-1:0]   count_unanswered;
    } t_result;

endpackage

`default_nettype wire

### rtl/sart_store.sv
// ----------------------------------------------------------------------------
// sart_store
// address and reply status memories, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sart_store #(
    parameter int DEPTH = sart_pkg::TABLE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic [AW-1:0]               i_raddr,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire sart_pkg::t_mem_we           i_we,
    input  wire logic [sart_pkg::ADDR_W-1:0] i_wdata_addr,
    input  wire sart_pkg::t_reply            i_wdata_stat,
    output      logic [sart_pkg::ADDR_W-1:0] o_rdata_addr,
    output      sart_pkg::t_reply            o_rdata_stat
);

    logic [sart_pkg::ADDR_W-1:0] r_addr_mem [DEPTH];
    sart_pkg::t_reply            r_stat_mem [DEPTH];

    // address memory
    always_ff @(posedge i_clk) begin
        if (i_we.addr_we) begin
            r_addr_mem[i_waddr] <= i_wdata_addr;
        end
        o_rdata_addr <= r_addr_mem[i_raddr];
    end

    // reply status memory
    always_ff @(posedge i_clk) begin
        if (i_we.stat_we) begin
            r_stat_mem[i_waddr] <= i_wdata_stat;
        end
        o_rdata_stat <= r_stat_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/sart_ctrl.sv
// ----------------------------------------------------------------------------
// sart_ctrl
// sequencer: binary search, entry shifting, status walks and result build
// ----------------------------------------------------------------------------
`default_nettype none

module sart_ctrl #(
    parameter int DEPTH = sart_pkg::TABLE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command
    input  wire logic                        i_start,
    input  wire sart_pkg::t_kind             i_kind,
    input  wire logic [sart_pkg::ADDR_W-1:0] i_key,
    input  wire logic                        i_reply_match,
    output      logic                        o_idle,
    // result
    output      logic                        o_res_valid,
    input  wire logic                        i_res_ready,
    output      sart_pkg::t_result           o_res,
    // memory port
    output      logic [AW-1:0]               o_raddr,
    output      logic [AW-1:0]               o_waddr,
    output      sart_pkg::t_mem_we           o_we,
    output      logic [sart_pkg::ADDR_W-1:0] o_wdata_addr,
    output      sart_pkg::t_reply            o_wdata_stat,
    input  wire logic [sart_pkg::ADDR_W-1:0] i_rdata_addr,
    input  wire sart_pkg::t_reply            i_rdata_stat
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_PROBE  = 8'b0000_0100,
        ST_CHECK  = 8'b0000_1000,
        ST_MOVE   = 8'b0001_0000,
        ST_PUT    = 8'b0010_0000,
        ST_WALK   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    localparam int CO = sart_pkg::CNT_OUT;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_rd_v, n_rd_v;
    sart_pkg::t_kind             r_kind, n_kind;
    logic [sart_pkg::ADDR_W-1:0] r_key, n_key;
    logic                        r_match, n_match;
    logic [CW-1:0]               r_lo, n_lo;
    logic [CW-1:0]               r_hi, n_hi;
    logic [AW-1:0]               r_src, n_src;
    logic [AW-1:0]               r_dst, n_dst;
    logic [CW-1:0]               r_left, n_left;
    sart_pkg::t_status           r_status, n_status;
    logic                        r_answered, n_answered;
    logic [CO-1:0]               r_c_ok, n_c_ok;
    logic [CO-1:0]               r_c_err, n_c_err;
    logic [CO-1:0]               r_c_sf, n_c_sf;
    logic [CO-1:0]               r_c_none, n_c_none;

    logic [CW-1:0]               mid;
    logic                        found;
    logic                        ins;

    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign found = (r_lo < r_count) && (i_rdata_addr == r_key);
    assign ins   = (r_kind == sart_pkg::K_ADD);

    // next state and memory access
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_v       = 1'b0;
        n_kind       = r_kind;
        n_key        = r_key;
        n_match      = r_match;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_src        = r_src;
        n_dst        = r_dst;
        n_left       = r_left;
        n_status     = r_status;
        n_answered   = r_answered;
        n_c_ok       = r_c_ok;
        n_c_err      = r_c_err;
        n_c_sf       = r_c_sf;
        n_c_none     = r_c_none;
        o_raddr      = AW'(r_lo);
        o_waddr      = r_dst;
        o_we         = '0;
        o_wdata_addr = i_rdata_addr;
        o_wdata_stat = i_rdata_stat;
        o_res_valid  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_kind     = i_kind;
                    n_key      = i_key;
                    n_match    = i_reply_match;
                    n_status   = sart_pkg::S_DONE;
                    n_answered = 1'b0;
                    n_c_ok     = '0;
                    n_c_err    = '0;
                    n_c_sf     = '0;
                    n_c_none   = '0;
                    n_lo       = '0;
                    n_hi       = r_count;
                    n_src      = '0;
                    n_left     = r_count;
                    unique case (i_kind)
                        sart_pkg::K_ADD, sart_pkg::K_DELETE, sart_pkg::K_QUERY,
                        sart_pkg::K_REPLY, sart_pkg::K_SEND_FAIL: begin
                            n_state = ST_SEARCH;
                        end
                        sart_pkg::K_CLEAR, sart_pkg::K_REPORT: begin
                            n_state = ST_WALK;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            // issue a probe read, or read the lower bound when narrowed
            ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    o_raddr = AW'(mid);
                    n_state = ST_PROBE;
                end else begin
                    o_raddr = AW'(r_lo);
                    n_state = ST_CHECK;
                end
            end

            // halve the range on the probed address
            ST_PROBE: begin
                if (i_rdata_addr < r_key) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = ST_SEARCH;
            end

            // act on the lower bound entry
            ST_CHECK: begin
                n_state = ST_DONE;
                o_waddr = AW'(r_lo);
                unique case (r_kind)
                    sart_pkg::K_ADD: begin
                        if (found) begin
                            n_status = sart_pkg::S_PRESENT;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_status = sart_pkg::S_FULL;
                        end else begin
                            n_src   = AW'(r_count - CW'(1));
                            n_left  = r_count - r_lo;
                            n_state = ST_MOVE;
                        end
                    end
                    sart_pkg::K_DELETE: begin
                        if (!found) begin
                            n_status = sart_pkg::S_ABSENT;
                        end else begin
                            n_src   = AW'(r_lo + CW'(1));
                            n_left  = r_count - r_lo - CW'(1);
                            n_state = ST_MOVE;
                        end
                    end
                    sart_pkg::K_QUERY: begin
                        if (!found) begin
                            n_status = sart_pkg::S_ABSENT;
                        end else begin
                            n_answered = (i_rdata_stat == sart_pkg::R_OK);
                        end
                    end
                    sart_pkg::K_REPLY: begin
                        if (!found) begin
                            n_status = sart_pkg::S_ABSENT;
                        end else begin
                            o_we.stat_we = 1'b1;
                            o_wdata_stat = r_match ? sart_pkg::R_OK : sart_pkg::R_ERROR;
                        end
                    end
                    sart_pkg::K_SEND_FAIL: begin
                        if (!found) begin
                            n_status = sart_pkg::S_ABSENT;
                        end else begin
                            o_we.stat_we = 1'b1;
                            o_wdata_stat = sart_pkg::R_SEND_FAIL;
                        end
                    end
                    default: begin
                        n_status = sart_pkg::S_DONE;
                    end
                endcase
            end

            // shift entries one place, read and write overlapped
            ST_MOVE: begin
                if (r_rd_v) begin
                    o_we.addr_we = 1'b1;
                    o_we.stat_we = 1'b1;
                end
                if (r_left != '0) begin
                    o_raddr = r_src;
                    n_src   = ins ? r_src - AW'(1) : r_src + AW'(1);
                    n_dst   = ins ? r_src + AW'(1) : r_src - AW'(1);
                    n_left  = r_left - CW'(1);
                    n_rd_v  = 1'b1;
                end else if (!r_rd_v) begin
                    if (ins) begin
                        n_state = ST_PUT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end
                end
            end

            // new entry goes into the opened slot
            ST_PUT: begin
                o_waddr      = AW'(r_lo);
                o_we.addr_we = 1'b1;
                o_we.stat_we = 1'b1;
                o_wdata_addr = r_key;
                o_wdata_stat = sart_pkg::R_NONE;
                n_count      = r_count + CW'(1);
                n_state      = ST_DONE;
            end

            // clear or tally every held status
            ST_WALK: begin
                if (r_left != '0) begin
                    o_raddr = r_src;
                    if (r_kind == sart_pkg::K_CLEAR) begin
                        o_waddr      = r_src;
                        o_we.stat_we = 1'b1;
                        o_wdata_stat = sart_pkg::R_NONE;
                    end
                    n_rd_v = (r_kind == sart_pkg::K_REPORT);
                    n_src  = r_src + AW'(1);
                    n_left = r_left - CW'(1);
                end else if (!r_rd_v) begin
                    n_state = ST_DONE;
                end
                if (r_rd_v) begin
                    unique case (i_rdata_stat)
                        sart_pkg::R_OK:        n_c_ok   = r_c_ok + CO'(1);
                        sart_pkg::R_ERROR:     n_c_err  = r_c_err + CO'(1);
                        sart_pkg::R_SEND_FAIL: n_c_sf   = r_c_sf + CO'(1);
                        default:               n_c_none = r_c_none + CO'(1);
                    endcase
                end
            end

            // hold the result until the output register takes it
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= n_rd_v;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_match    <= n_match;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_left     <= n_left;
        r_status   <= n_status;
        r_answered <= n_answered;
        r_c_ok     <= n_c_ok;
        r_c_err    <= n_c_err;
        r_c_sf     <= n_c_sf;
        r_c_none   <= n_c_none;
    end

    // result word
    always_comb begin
        o_res.status           = r_status;
        o_res.answered         = r_answered;
        o_res.entry_count      = CO'(r_count);
        o_res.count_ok         = r_c_ok;
        o_res.count_error      = r_c_err;
        o_res.count_send_fail  = r_c_sf;
        o_res.count_unanswered = r_c_none;
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

`default_nettype wire

### rtl/sorted_address_reply_table.sv
// ----------------------------------------------------------------------------
// sorted_address_reply_table
// sorted IPv4 address table with per-address echo reply status
// ----------------------------------------------------------------------------
// Each input word is one command on a table of up to DEPTH addresses kept in
// ascending order in a memory with one registered read and one write port.
// Commands run one at a time. Add, delete, query, reply and send-failure
// first binary search the table through the read port, each step issuing a
// probe read and then halving the range on the probed address. Add then
// shifts the n-p entries above the insert point p, n being the held entries,
// drains the last shift and writes the new entry; delete shifts n-p-1
// entries. Clear walks all n entries one per cycle; report also waits for
// the last read. Every command is taken in the idle state and ends with the
// handoff to the output register. No clearing pass follows reset; a slot
// past the held entries may be read, but what it holds is never used. A
// result waiting at the output does not stop the next command from being
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_address_reply_table #(
    parameter int DEPTH = sart_pkg::TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // echo id register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    // command stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // address, reply_id, reply_type, reply_code
    input  wire logic [2:0]  i_s_tuser,  // kind
    // result stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [39:0] o_m_tdata   // status, answered, entry_count, count_ok,
                                         // count_error, count_send_fail,
                                         // count_unanswered, zero fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [sart_pkg::ID_W-1:0]   r_echo_id;
    logic                        start;
    logic                        reply_match;
    logic                        idle;
    logic                        res_valid;
    logic                        res_ready;
    sart_pkg::t_result           res;
    logic [AW-1:0]               raddr;
    logic [AW-1:0]               waddr;
    sart_pkg::t_mem_we           we;
    logic [sart_pkg::ADDR_W-1:0] wdata_addr;
    sart_pkg::t_reply            wdata_stat;
    logic [sart_pkg::ADDR_W-1:0] rdata_addr;
    sart_pkg::t_reply            rdata_stat;
    logic                        r_m_valid;
    logic [39:0]                 r_m_data;

    // echo id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_id <= '0;
        end else if (i_cfg_wr_en) begin
            r_echo_id <= i_cfg_wr_data;
        end
    end

    // input handshake and reply check
    assign o_s_tready  = idle;
    assign start       = i_s_tvalid && idle;
    assign reply_match = (i_s_tdata[47:32] == r_echo_id) && (i_s_tdata[55:48] == 8'd0)
                         && (i_s_tdata[63:56] == 8'd0);

    sart_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_kind        (sart_pkg::t_kind'(i_s_tuser)),
        .i_key         (i_s_tdata[31:0]),
        .i_reply_match (reply_match),
        .o_idle        (idle),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_raddr       (raddr),
        .o_waddr       (waddr),
        .o_we          (we),
        .o_wdata_addr  (wdata_addr),
        .o_wdata_stat  (wdata_stat),
        .i_rdata_addr  (rdata_addr),
        .i_rdata_stat  (rdata_stat)
    );

    sart_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_raddr      (raddr),
        .i_waddr      (waddr),
        .i_we         (we),
        .i_wdata_addr (wdata_addr),
        .i_wdata_stat (wdata_stat),
        .o_rdata_addr (rdata_addr),
        .o_rdata_stat (rdata_stat)
    );

    // output register
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_data <= {2'b00, res.count_unanswered, res.count_send_fail,
                         res.count_error, res.count_ok, res.entry_count,
                         res.answered, res.status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

### bench/sart_checker.sv
// ----------------------------------------------------------------------------
// sart_checker
// watches both streams of the sorted address reply table, keeps a shadow
// copy of the table, predicts one result word per command word and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sart_checker
    import sart_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,  // address, reply_id, reply_type, reply_code
    input  wire logic [2:0]  i_s_tuser,  // kind
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,  // status, answered, entry_count, count_ok,
                                         // count_error, count_send_fail,
                                         // count_unanswered, zero fill
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_full_hits
);

    // shadow table, kept ascending
    logic [ADDR_W-1:0] shadow_addr  [TABLE_DEPTH];
    t_reply            shadow_reply [TABLE_DEPTH];
    int                shadow_held;
    logic [ID_W-1:0]   shadow_echo_id;
    t_result           awaited_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_hits  = 0;
        shadow_held  = 0;
    end

    // lower bound: first slot whose address is not below the key
    function automatic int first_not_below(logic [ADDR_W-1:0] key);
        int lo, hi, mid;
        lo = 0;
        hi = shadow_held;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_addr[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // run one command on the shadow table and build its result word
    function automatic t_result apply_command(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                              logic [ID_W-1:0] rid, logic [BYTE_W-1:0] rtype,
                                              logic [BYTE_W-1:0] rcode);
        t_result r;
        int      pos;
        bit      hit;
        r   = '0;
        pos = first_not_below(addr);
        hit = (pos < shadow_held) && (shadow_addr[pos] == addr);
        case (kind)
            K_ADD: begin
                if (hit) begin
                    r.status = S_PRESENT;
                end else if (shadow_held >= TABLE_DEPTH) begin
                    r.status = S_FULL;
                end else begin
                    for (int i = shadow_held; i > pos; i--) begin
                        shadow_addr[i]  = shadow_addr[i-1];
                        shadow_reply[i] = shadow_reply[i-1];
                    end
                    shadow_addr[pos]  = addr;
                    shadow_reply[pos] = R_NONE;
                    shadow_held++;
                end
            end
            K_DELETE: begin
                if (!hit) begin
                    r.status = S_ABSENT;
                end else begin
                    for (int i = pos; i < shadow_held - 1; i++) begin
                        shadow_addr[i]  = shadow_addr[i+1];
                        shadow_reply[i] = shadow_reply[i+1];
                    end
                    shadow_held--;
                end
            end
            K_QUERY: begin
                if (!hit)
                    r.status = S_ABSENT;
                else
                    r.answered = (shadow_reply[pos] == R_OK);
            end
            K_CLEAR: begin
                for (int i = 0; i < shadow_held; i++)
                    shadow_reply[i] = R_NONE;
            end
            K_REPLY: begin
                if (!hit)
                    r.status = S_ABSENT;
                else if (rid == shadow_echo_id && rtype == '0 && rcode == '0)
                    shadow_reply[pos] = R_OK;
                else
                    shadow_reply[pos] = R_ERROR;
            end
            K_SEND_FAIL: begin
                if (!hit)
                    r.status = S_ABSENT;
                else
                    shadow_reply[pos] = R_SEND_FAIL;
            end
            K_REPORT: begin
                for (int i = 0; i < shadow_held; i++) begin
                    case (shadow_reply[i])
                        R_OK:        r.count_ok         = r.count_ok + 1'b1;
                        R_ERROR:     r.count_error      = r.count_error + 1'b1;
                        R_SEND_FAIL: r.count_send_fail  = r.count_send_fail + 1'b1;
                        default:     r.count_unanswered = r.count_unanswered + 1'b1;
                    endcase
                end
            end
            default: ;  // unused kind leaves everything alone
        endcase
        r.entry_count = CNT_OUT'(shadow_held);
        return r;
    endfunction

    // one field of a result word against its prediction
    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    // observe the channels
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            shadow_held    = 0;
            shadow_echo_id = '0;
            awaited_words.delete();
        end else begin
            if (i_cfg_wr_en)
                shadow_echo_id = i_cfg_wr_data;
            // result word first, so a command taken at the same edge queues behind it
            if (i_m_tvalid && i_m_tready) begin
                got.status           = t_status'(i_m_tdata[1:0]);
                got.answered         = i_m_tdata[2];
                got.entry_count      = i_m_tdata[9:3];
                got.count_ok         = i_m_tdata[16:10];
                got.count_error      = i_m_tdata[23:17];
                got.count_send_fail  = i_m_tdata[30:24];
                got.count_unanswered = i_m_tdata[37:31];
                if (awaited_words.size() == 0) begin
                    $display("%0t ns: result word %h with nothing expected", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = awaited_words.pop_front();
                    o_checked++;
                    if (want.status == S_FULL)
                        o_full_hits++;
                    check_field("status", want.status, got.status);
                    check_field("answered", want.answered, got.answered);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("count_ok", want.count_ok, got.count_ok);
                    check_field("count_error", want.count_error, got.count_error);
                    check_field("count_send_fail", want.count_send_fail,
                                got.count_send_fail);
                    check_field("count_unanswered", want.count_unanswered,
                                got.count_unanswered);
                    check_field("zero fill", 0, i_m_tdata[39:38]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_words.push_back(apply_command(i_s_tuser, i_s_tdata[31:0],
                                                      i_s_tdata[47:32], i_s_tdata[55:48],
                                                      i_s_tdata[63:56]));
        end
        o_pending <= awaited_words.size();
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives command words into the sorted address reply table under several
// idling patterns and echo id settings; the checker beside it compares
// every result word against a shadow table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import sart_pkg::*;

    localparam logic [2:0] KIND_UNUSED   = 3'd7;
    localparam int         POOL_SIZE     = 80;
    localparam int         PHASES        = 6;
    localparam int         WORDS_A_PHASE = 245;
    localparam int         HOLD_CYCLES   = 2000;
    localparam int         SETTLE_CYCLES = 200;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic [2:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    bit          long_hold      = 1'b0;
    int          hold_count     = 0;
    logic [15:0] echo_now       = '0;
    logic [31:0] addr_pool [POOL_SIZE];
    int          kind_sent [8];
    int          add_weight [PHASES] = '{60, 40, 25, 10, 70, 15};
    int          fail_count, pending, checked, full_hits;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_address_reply_table uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata)
    );

    sart_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_full_hits   (full_hits)
    );

    // result side: random stalls, plus one long hold-off when asked
    always @(posedge clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end else begin
            if (!long_hold)
                hold_count <= 0;
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic write_echo_id(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        echo_now     = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // offer one command word and wait until it is taken
    task automatic send_cmd(logic [2:0] kind, logic [31:0] addr, logic [15:0] rid,
                            logic [7:0] rtype, logic [7:0] rcode);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rcode, rtype, rid, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        kind_sent[kind]++;
    endtask

    // stop offering and wait for every outstanding result word
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // mostly pool addresses so adds, replies and deletes hit held entries
    task automatic send_random(int add_pct);
        logic [31:0] addr;
        logic [15:0] rid;
        logic [7:0]  rtype, rcode;
        logic [2:0]  kind;
        int          pick;
        addr  = ($urandom_range(9) == 0) ? $urandom : addr_pool[$urandom_range(POOL_SIZE-1)];
        rid   = ($urandom_range(3) != 0) ? echo_now : 16'($urandom);
        rtype = ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00;
        rcode = ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00;
        if ($urandom_range(99) < add_pct) begin
            kind = K_ADD;
        end else begin
            pick = $urandom_range(99);
            if (pick < 22)      kind = K_DELETE;
            else if (pick < 44) kind = K_QUERY;
            else if (pick < 74) kind = K_REPLY;
            else if (pick < 84) kind = K_SEND_FAIL;
            else if (pick < 87) kind = K_CLEAR;
            else if (pick < 97) kind = K_REPORT;
            else                kind = KIND_UNUSED;
        end
        send_cmd(kind, addr, rid, rtype, rcode);
    endtask

    // stimulus
    initial begin
        int mode;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, each reply outcome, clear, unused kind
        write_echo_id(16'hFFFF);
        send_cmd(K_REPORT,    32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_QUERY,     32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_DELETE,    32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_REPLY,     32'h0000_0001, 16'hFFFF, 8'h00, 8'h00);
        send_cmd(K_SEND_FAIL, 32'h0000_0002, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_ADD,       32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_ADD,       32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_ADD,       32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_ADD,       32'h8000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_ADD,       32'h7FFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_REPLY,     32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'h00);
        send_cmd(K_REPLY,     32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_REPLY,     32'h8000_0000, 16'hFFFF, 8'h08, 8'h00);
        send_cmd(K_REPLY,     32'h7FFF_FFFF, 16'hFFFF, 8'h00, 8'hFF);
        send_cmd(K_SEND_FAIL, 32'h8000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_QUERY,     32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_QUERY,     32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_REPORT,    32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        // re-adding keeps the ok status
        send_cmd(K_ADD,       32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_QUERY,     32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_CLEAR,     32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_cmd(K_QUERY,     32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_DELETE,    32'hFFFF_FFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(K_DELETE,    32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        send_cmd(KIND_UNUSED, 32'h8000_0000, 16'hFFFF, 8'h00, 8'h00);
        send_cmd(K_REPORT,    32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);

        // random phases; mode cycles none / sender idle / receiver stall / both
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p == 1)
                write_echo_id(16'hFFFF);
            else if (p == 4)
                write_echo_id(16'h0000);
            else
                write_echo_id(16'($urandom));
            mode           = p % 4;
            src_idle_pct   = (mode == 1) ? 86 : (mode == 3) ? 8 : 0;
            sink_stall_pct <= (mode == 2) ? 86 : (mode == 3) ? 8 : 0;
            long_hold      <= (p == 2);
            for (int n = 0; n < WORDS_A_PHASE; n++)
                send_random(add_weight[p]);
            long_hold <= 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d add, %0d delete, %0d query, %0d reply, %0d send-fail, %0d clear,",
                 kind_sent[K_ADD], kind_sent[K_DELETE], kind_sent[K_QUERY],
                 kind_sent[K_REPLY], kind_sent[K_SEND_FAIL], kind_sent[K_CLEAR]);
        $display("%0d report, %0d unused-kind words; %0d results compared, %0d full-table rejects",
                 kind_sent[K_REPORT], kind_sent[KIND_UNUSED], checked, full_hits);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/sart_pkg.sv
rtl/sart_store.sv
rtl/sart_ctrl.sv
rtl/sorted_address_reply_table.sv
bench/sart_checker.sv
bench/tb_top.sv
